// ----- hdl/bti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bti_pkg
// Shared types, constants and the control store for the breakpoint table
// interpolator.
// ---------------------------------------------------------------------------
package bti_pkg;

  // Field widths fixed by the item format
  localparam int DATA_W = 16;
  localparam int IDX_W  = 4;
  localparam int TABLE_ROWS_DEFAULT = 16;

  // Divider: one quotient bit per step
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Program counter
  localparam int STEP_W = 4;

  // Read address select
  localparam logic [1:0] RD_NONE  = 2'd0;
  localparam logic [1:0] RD_LAST  = 2'd1;
  localparam logic [1:0] RD_FIRST = 2'd2;
  localparam logic [1:0] RD_MID   = 2'd3;

  // Datapath actions
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_INIT    = 4'd1;
  localparam logic [3:0] ACT_CAP_HI  = 4'd2;
  localparam logic [3:0] ACT_CAP_LO  = 4'd3;
  localparam logic [3:0] ACT_PROBE   = 4'd4;
  localparam logic [3:0] ACT_SEG     = 4'd5;
  localparam logic [3:0] ACT_MUL     = 4'd6;
  localparam logic [3:0] ACT_DIVINIT = 4'd7;
  localparam logic [3:0] ACT_DIVSTEP = 4'd8;
  localparam logic [3:0] ACT_FINISH  = 4'd9;
  localparam logic [3:0] ACT_EMIT    = 4'd10;

  // Result loads, applied when the step's jump is taken
  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_YHI   = 2'd1;
  localparam logic [1:0] RES_YLO   = 2'd2;
  localparam logic [1:0] RES_DEGEN = 2'd3;

  // Jump conditions
  localparam logic [2:0] JC_NONE        = 3'd0;
  localparam logic [2:0] JC_ALWAYS      = 3'd1;
  localparam logic [2:0] JC_START       = 3'd2;
  localparam logic [2:0] JC_CLAMP_LAST  = 3'd3;
  localparam logic [2:0] JC_CLAMP_FIRST = 3'd4;
  localparam logic [2:0] JC_SPAN1       = 3'd5;
  localparam logic [2:0] JC_DEGEN       = 3'd6;
  localparam logic [2:0] JC_DIV_MORE    = 3'd7;

  // Program steps
  localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd0;
  localparam logic [STEP_W-1:0] STEP_INIT    = 4'd1;
  localparam logic [STEP_W-1:0] STEP_RDF     = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CAPLO   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CLAMPL  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CLAMPF  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_SRCH    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_PROBE   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_SEG     = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MUL     = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIVINIT = 4'd10;
  localparam logic [STEP_W-1:0] STEP_DIV     = 4'd11;
  localparam logic [STEP_W-1:0] STEP_FINISH  = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd13;

  typedef struct packed {
    logic [1:0]        rd_sel;
    logic [3:0]        act;
    logic [1:0]        res;
    logic [2:0]        cond;
    logic              hold;    // stay on this step while cond is false
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic start;
    logic clamp_last;
    logic clamp_first;
    logic span1;
    logic degen;
    logic div_more;
    logic out_free;
  } status_t;

  // Control store
  function automatic ctrl_t rom_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    case (step)
      STEP_IDLE:    w = '{RD_NONE,  ACT_NONE,    RES_NONE,  JC_START,       1'b1, STEP_INIT};
      STEP_INIT:    w = '{RD_LAST,  ACT_INIT,    RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_RDF:     w = '{RD_FIRST, ACT_CAP_HI,  RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_CAPLO:   w = '{RD_NONE,  ACT_CAP_LO,  RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_CLAMPL:  w = '{RD_NONE,  ACT_NONE,    RES_YHI,   JC_CLAMP_LAST,  1'b0, STEP_EMIT};
      STEP_CLAMPF:  w = '{RD_NONE,  ACT_NONE,    RES_YLO,   JC_CLAMP_FIRST, 1'b0, STEP_EMIT};
      STEP_SRCH:    w = '{RD_MID,   ACT_NONE,    RES_NONE,  JC_SPAN1,       1'b0, STEP_SEG};
      STEP_PROBE:   w = '{RD_NONE,  ACT_PROBE,   RES_NONE,  JC_ALWAYS,      1'b0, STEP_SRCH};
      STEP_SEG:     w = '{RD_NONE,  ACT_SEG,     RES_DEGEN, JC_DEGEN,       1'b0, STEP_EMIT};
      STEP_MUL:     w = '{RD_NONE,  ACT_MUL,     RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_DIVINIT: w = '{RD_NONE,  ACT_DIVINIT, RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_DIV:     w = '{RD_NONE,  ACT_DIVSTEP, RES_NONE,  JC_DIV_MORE,    1'b0, STEP_DIV};
      STEP_FINISH:  w = '{RD_NONE,  ACT_FINISH,  RES_NONE,  JC_NONE,        1'b0, STEP_IDLE};
      STEP_EMIT:    w = '{RD_NONE,  ACT_EMIT,    RES_NONE,  JC_START,       1'b1, STEP_IDLE};
      default:      w = '{RD_NONE,  ACT_NONE,    RES_NONE,  JC_ALWAYS,      1'b0, STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/bti_channels.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bti_channels
// Valid/ready channels: input items, result items and the mode register.
// ---------------------------------------------------------------------------
interface bti_item_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [3:0]  entry_index;
  logic [15:0] entry_x;
  logic [15:0] entry_y;
  logic [15:0] sample;
  modport source (output valid, action, entry_index, entry_x, entry_y, sample,
                  input ready);
  modport sink   (input valid, action, entry_index, entry_x, entry_y, sample,
                  output ready);
endinterface

interface bti_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] mapped_value;
  logic        degenerate_segment;
  modport source (output valid, mapped_value, degenerate_segment, input ready);
  modport sink   (input valid, mapped_value, degenerate_segment, output ready);
endinterface

interface bti_cfg_if;
  logic valid;
  logic ready;
  logic descending_mode;
  modport source (output valid, descending_mode, input ready);
  modport sink   (input valid, descending_mode, output ready);
endinterface
`default_nettype wire

// ----- hdl/breakpoint_table_interpolator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// breakpoint_table_interpolator
// Piecewise linear lookup through a table of (x, y) breakpoints.
// ---------------------------------------------------------------------------
// Use:
//   items:   valid/ready input. action 0 writes row entry_index (rows at or
//            past TABLE_ROWS are dropped); action 1 looks up sample.
//   results: valid/ready output, one beat per lookup, none per write.
//   cfg:     write of descending_mode, always ready; write only when idle.
// Timing:
//   A write beat is absorbed in its accept cycle and ready stays high.
//   A lookup runs a microprogram: setup and clamp checks, a search step and a
//   probe step per search probe plus a closing search step, then segment,
//   multiply, divider setup, the divider steps, a final add and the hand-off;
//   at 16 rows a search takes 3 or 4 probes; a clamped lookup goes straight
//   to the hand-off. The divider and the single read port set a lookup's length.
//   items.ready is low from a lookup's accept until its result reaches the
//   output register, which then frees the sequencer.
// Reset: clears descending_mode, the sequencer and the output valid. Table
//   rows hold nothing until written. A stalled result holds in the output
//   register; the next item is taken meanwhile, and its result waits at the
//   final step until the register frees.
// ---------------------------------------------------------------------------
module breakpoint_table_interpolator #(
  parameter int TABLE_ROWS = bti_pkg::TABLE_ROWS_DEFAULT
) (
  input wire            clk,
  input wire            rst,
  bti_item_if.sink      items,
  bti_result_if.source  results,
  bti_cfg_if.sink       cfg
);
  import bti_pkg::*;

  localparam int ROW_W = $clog2(TABLE_ROWS);

  ctrl_t              ctrl;
  status_t            status;
  logic               taken;
  logic               idle;
  logic               item_beat;
  logic [ROW_W-1:0]   rd_addr;
  logic [DATA_W-1:0]  rd_x;
  logic [DATA_W-1:0]  rd_y;

  // Handshakes
  assign items.ready = idle;
  assign cfg.ready   = 1'b1;
  assign item_beat   = items.valid && idle;

  bti_table #(.TABLE_ROWS(TABLE_ROWS)) u_table (
    .clk      (clk),
    .wr_en    (item_beat && !items.action),
    .wr_index (items.entry_index),
    .wr_x     (items.entry_x),
    .wr_y     (items.entry_y),
    .rd_addr  (rd_addr),
    .rd_x     (rd_x),
    .rd_y     (rd_y)
  );

  bti_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl),
    .taken  (taken),
    .idle   (idle)
  );

  bti_datapath #(.TABLE_ROWS(TABLE_ROWS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .taken     (taken),
    .start     (item_beat && items.action),
    .sample    (items.sample),
    .cfg_we    (cfg.valid),
    .cfg_desc  (cfg.descending_mode),
    .rd_addr   (rd_addr),
    .rd_x      (rd_x),
    .rd_y      (rd_y),
    .status    (status),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .out_value (results.mapped_value),
    .out_flag  (results.degenerate_segment)
  );

endmodule
`default_nettype wire

// ----- hdl/bti_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bti_table
// Breakpoint store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bti_table #(
  parameter int TABLE_ROWS = bti_pkg::TABLE_ROWS_DEFAULT
) (
  input  wire                                  clk,
  input  wire                                  wr_en,
  input  wire  [bti_pkg::IDX_W-1:0]            wr_index,
  input  wire  [bti_pkg::DATA_W-1:0]           wr_x,
  input  wire  [bti_pkg::DATA_W-1:0]           wr_y,
  input  wire  [$clog2(TABLE_ROWS)-1:0]        rd_addr,
  output logic [bti_pkg::DATA_W-1:0]           rd_x,
  output logic [bti_pkg::DATA_W-1:0]           rd_y
);
  import bti_pkg::*;

  localparam int ROW_W = $clog2(TABLE_ROWS);
  localparam int CMP_W = ROW_W + IDX_W;

  logic [2*DATA_W-1:0] mem [TABLE_ROWS];
  logic [CMP_W-1:0]    wr_wide;
  logic                wr_ok;

  // Rows at or beyond the table size are dropped
  assign wr_wide = CMP_W'(wr_index);
  assign wr_ok   = wr_en && (wr_wide < CMP_W'(TABLE_ROWS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_wide[ROW_W-1:0]] <= {wr_x, wr_y};
    end
  end

  always_ff @(posedge clk) begin
    {rd_x, rd_y} <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- hdl/bti_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bti_sequencer
// Step counter over the control store with conditional jumps.
// ---------------------------------------------------------------------------
module bti_sequencer (
  input  wire               clk,
  input  wire               rst,
  input  bti_pkg::status_t  status,
  output bti_pkg::ctrl_t    ctrl,
  output logic              taken,
  output logic              idle
);
  import bti_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;

  assign ctrl = rom_word(pc);
  assign idle = (pc == STEP_IDLE);

  // Jump condition mux
  always_comb begin
    case (ctrl.cond)
      JC_NONE:        taken = 1'b0;
      JC_ALWAYS:      taken = 1'b1;
      JC_START:       taken = (pc == STEP_IDLE) ? status.start : status.out_free;
      JC_CLAMP_LAST:  taken = status.clamp_last;
      JC_CLAMP_FIRST: taken = status.clamp_first;
      JC_SPAN1:       taken = status.span1;
      JC_DEGEN:       taken = status.degen;
      JC_DIV_MORE:    taken = status.div_more;
      default:        taken = 1'b0;
    endcase
  end

  // Next step
  always_comb begin
    if (taken) begin
      pc_next = ctrl.target;
    end else if (ctrl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pc <= STEP_EMIT)
    else $error("step counter left the program");
  assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT && status.out_free) |=> pc == STEP_IDLE)
    else $error("result handed off but sequencer not idle");
  assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_IDLE && !status.start) |=> pc == STEP_IDLE)
    else $error("sequencer left idle without a lookup");

endmodule
`default_nettype wire

// ----- hdl/bti_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// bti_datapath
// Search bounds, segment arithmetic, serial divider and output register.
// ---------------------------------------------------------------------------
module bti_datapath #(
  parameter int TABLE_ROWS = bti_pkg::TABLE_ROWS_DEFAULT
) (
  input  wire                             clk,
  input  wire                             rst,
  input  bti_pkg::ctrl_t                  ctrl,
  input  wire                             taken,
  input  wire                             start,
  input  wire  [bti_pkg::DATA_W-1:0]      sample,
  input  wire                             cfg_we,
  input  wire                             cfg_desc,
  output logic [$clog2(TABLE_ROWS)-1:0]   rd_addr,
  input  wire  [bti_pkg::DATA_W-1:0]      rd_x,
  input  wire  [bti_pkg::DATA_W-1:0]      rd_y,
  output bti_pkg::status_t                status,
  input  wire                             out_ready,
  output logic                            out_valid,
  output logic [bti_pkg::DATA_W-1:0]      out_value,
  output logic                            out_flag
);
  import bti_pkg::*;

  localparam int ROW_W = $clog2(TABLE_ROWS);
  localparam int PROD_W = 2 * (DATA_W + 1);
  localparam logic [ROW_W-1:0] LAST = ROW_W'(TABLE_ROWS - 1);

  logic                     desc;
  logic [DATA_W-1:0]        s;
  logic [ROW_W-1:0]         lo;
  logic [ROW_W-1:0]         hi;
  logic [DATA_W-1:0]        x_lo, y_lo, x_hi, y_hi;
  logic signed [DATA_W:0]   d, dy, dx;
  logic signed [PROD_W-1:0] prod;
  logic [DATA_W-1:0]        rem, quo, dxm;
  logic                     neg;
  logic [DIV_CNT_W-1:0]     cnt;
  logic [DATA_W-1:0]        res_value;
  logic                     res_flag;

  logic [ROW_W:0]           mid_sum;
  logic [ROW_W-1:0]         mid;
  logic                     goes_left;
  logic [PROD_W-1:0]        mag;
  logic [DATA_W:0]          trial;
  logic                     ge;
  logic                     out_free;

  // Probe index and read address
  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid     = mid_sum[ROW_W:1];

  always_comb begin
    case (ctrl.rd_sel)
      RD_LAST:  rd_addr = LAST;
      RD_FIRST: rd_addr = '0;
      default:  rd_addr = mid;
    endcase
  end

  // Compares
  assign goes_left = desc ? (s > rd_x) : (s < rd_x);
  assign out_free  = !out_valid || out_ready;

  assign status.start       = start;
  assign status.clamp_last  = desc ? (s <= x_hi) : (s >= x_hi);
  assign status.clamp_first = desc ? (s > x_lo) : (s < x_lo);
  assign status.span1       = (hi - lo) <= ROW_W'(1);
  assign status.degen       = (x_hi == x_lo);
  assign status.div_more    = (cnt != DIV_CNT_W'(DIV_STEPS - 1));
  assign status.out_free    = out_free;

  // Divider helpers
  assign mag   = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
  assign trial = {rem, quo[DATA_W-1]};
  assign ge    = trial >= {1'b0, dxm};

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      desc <= 1'b0;
    end else if (cfg_we) begin
      desc <= cfg_desc;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (start) begin
      s <= sample;
    end
    case (ctrl.act)
      ACT_INIT: begin
        lo <= '0;
        hi <= LAST;
      end
      ACT_CAP_HI: begin
        x_hi <= rd_x;
        y_hi <= rd_y;
      end
      ACT_CAP_LO: begin
        x_lo <= rd_x;
        y_lo <= rd_y;
      end
      ACT_PROBE: begin
        if (goes_left) begin
          hi   <= mid;
          x_hi <= rd_x;
          y_hi <= rd_y;
        end else begin
          lo   <= mid;
          x_lo <= rd_x;
          y_lo <= rd_y;
        end
      end
      ACT_SEG: begin
        d  <= $signed({1'b0, s})    - $signed({1'b0, x_lo});
        dy <= $signed({1'b0, y_hi}) - $signed({1'b0, y_lo});
        dx <= $signed({1'b0, x_hi}) - $signed({1'b0, x_lo});
      end
      ACT_MUL: begin
        prod <= PROD_W'(d) * PROD_W'(dy);
      end
      ACT_DIVINIT: begin
        // |d| < |dx| inside a segment, so the quotient fits DATA_W bits
        rem <= mag[2*DATA_W-1:DATA_W];
        quo <= mag[DATA_W-1:0];
        dxm <= dx[DATA_W] ? DATA_W'(-dx) : dx[DATA_W-1:0];
        neg <= prod[PROD_W-1] ^ dx[DATA_W];
        cnt <= '0;
      end
      ACT_DIVSTEP: begin
        rem <= ge ? DATA_W'(trial - {1'b0, dxm}) : trial[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], ge};
        cnt <= cnt + DIV_CNT_W'(1);
      end
      ACT_FINISH: begin
        res_value <= y_lo + (neg ? DATA_W'(-quo) : quo);
        res_flag  <= 1'b0;
      end
      default: begin
      end
    endcase
    // Clamp and degenerate results
    if (taken) begin
      case (ctrl.res)
        RES_YHI: begin
          res_value <= y_hi;
          res_flag  <= 1'b0;
        end
        RES_YLO: begin
          res_value <= y_lo;
          res_flag  <= 1'b0;
        end
        RES_DEGEN: begin
          res_value <= y_lo;
          res_flag  <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.act == ACT_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ACT_EMIT && out_free) begin
      out_value <= res_value;
      out_flag  <= res_flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (ctrl.act == ACT_PROBE) |-> lo < hi)
    else $error("search bounds crossed");
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_SEG) |-> (hi - lo) == ROW_W'(1))
    else $error("segment reached before search converged");
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.act == ACT_EMIT && out_free) |=> out_valid)
    else $error("result lost at hand-off");

endmodule
`default_nettype wire
